/* sv/tmq_pkg.sv */
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants of the timed message queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

  // default sizes
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 8;
  localparam int unsigned TIME_BITS       = 32;

  // operation codes on the request channel
  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_NEXT    = 2'd1,
    MODE_QUIT    = 2'd2
  } mode_e;

  // result codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IN_USE    = 3'd1,
    ST_NO_TARGET = 3'd2,
    ST_QUITTING  = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_ENDED     = 3'd6
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PUT,
    S_POP,
    S_QUIT_SCAN,
    S_DONE
  } state_e;

endpackage

/* sv/tmq_if.sv */
// ----------------------------------------------------------------------------
// tmq_if
// Request and result channels of the timed message queue.
// ----------------------------------------------------------------------------
interface tmq_in_if
  import tmq_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [HANDLE_BITS-1:0] msg_handle;
  logic [TIME_BITS-1:0]   due_time;
  logic                   has_target;
  logic                   already_used;
  logic                   safe_quit;
  logic [TIME_BITS-1:0]   time_now;

  modport source (output valid, mode, msg_handle, due_time, has_target, already_used,
                  safe_quit, time_now, input ready);
  modport sink   (input valid, mode, msg_handle, due_time, has_target, already_used,
                  safe_quit, time_now, output ready);
endinterface

interface tmq_out_if
  import tmq_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [HANDLE_BITS-1:0] out_handle;

  modport source (output valid, status, out_handle, input ready);
  modport sink   (input valid, status, out_handle, output ready);
endinterface

/* sv/tmq_mem.sv */
// ----------------------------------------------------------------------------
// tmq_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmq_mem
  import tmq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = TIME_BITS + HANDLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/tmq_ctrl.sv */
// ----------------------------------------------------------------------------
// tmq_ctrl
// Sequencer of the queue: circular buffer pointers, sorted insert by a
// backward scan of the slot memory, pop at the head, quit trimming.
// ----------------------------------------------------------------------------
module tmq_ctrl
  import tmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned DW = TIME_BITS + HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tmq_in_if.sink                 in_i,
  // result toward the output register
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output status_e                res_status_o,
  output logic [HANDLE_BITS-1:0] res_handle_o,
  // slot memory
  output logic                   mem_we_o,
  output logic [IW-1:0]          mem_waddr_o,
  output logic [DW-1:0]          mem_wdata_o,
  output logic                   mem_re_o,
  output logic [IW-1:0]          mem_raddr_o,
  input  logic [DW-1:0]          mem_rdata_i
);

  state_e                 state_q, state_d;
  logic [IW-1:0]          head_q, head_d;
  logic [IW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   quitting_q, quitting_d;
  logic [IW-1:0]          rd_q, rd_d;
  logic [IW-1:0]          wr_q, wr_d;
  logic [CW-1:0]          left_q, left_d;
  logic [TIME_BITS-1:0]   key_q, key_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  status_e                status_q, status_d;
  logic [HANDLE_BITS-1:0] out_hdl_q, out_hdl_d;

  logic [TIME_BITS-1:0]   rd_time;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   later;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
    ptr_dec = (p == '0) ? IW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  assign rd_time   = mem_rdata_i[DW-1 -: TIME_BITS];
  assign rd_handle = mem_rdata_i[HANDLE_BITS-1:0];
  // entry just read is due after the key
  assign later     = rd_time > key_q;

  assign in_i.ready   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_status_o = status_q;
  assign res_handle_o = out_hdl_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      quitting_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      quitting_q <= quitting_d;
    end
  end

  // scan and result registers
  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    left_q    <= left_d;
    key_q     <= key_d;
    hdl_q     <= hdl_d;
    status_q  <= status_d;
    out_hdl_q <= out_hdl_d;
  end

  // next state and memory requests
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    quitting_d  = quitting_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    left_d      = left_q;
    key_d       = key_q;
    hdl_d       = hdl_q;
    status_d    = status_q;
    out_hdl_d   = out_hdl_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = {key_q, hdl_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_dec(rd_q);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          hdl_d     = in_i.msg_handle;
          key_d     = (in_i.mode == MODE_QUIT) ? in_i.time_now : in_i.due_time;
          status_d  = ST_OK;
          out_hdl_d = '0;
          state_d   = S_DONE;
          case (in_i.mode)
            MODE_ENQUEUE: begin
              if (in_i.already_used) begin
                status_d = ST_IN_USE;
              end else if (!in_i.has_target) begin
                status_d = ST_NO_TARGET;
              end else if (quitting_q) begin
                status_d = ST_QUITTING;
              end else if (count_q == CW'(QUEUE_DEPTH)) begin
                status_d = ST_FULL;
              end else if (in_i.due_time == '0) begin
                // due now: goes in front of the head
                mem_we_o    = 1'b1;
                mem_waddr_o = ptr_dec(head_q);
                mem_wdata_o = {in_i.due_time, in_i.msg_handle};
                head_d      = ptr_dec(head_q);
                count_d     = count_q + 1'b1;
              end else if (count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = tail_q;
                mem_wdata_o = {in_i.due_time, in_i.msg_handle};
                tail_d      = ptr_inc(tail_q);
                count_d     = count_q + 1'b1;
              end else begin
                // walk back from the tail, moving later entries up
                mem_re_o    = 1'b1;
                mem_raddr_o = ptr_dec(tail_q);
                rd_d        = ptr_dec(tail_q);
                wr_d        = tail_q;
                left_d      = count_q;
                state_d     = S_INS_SCAN;
              end
            end
            MODE_NEXT: begin
              if (count_q == '0) begin
                status_d = quitting_q ? ST_ENDED : ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = S_POP;
              end
            end
            MODE_QUIT: begin
              if (!quitting_q) begin
                quitting_d = 1'b1;
                if (!in_i.safe_quit) begin
                  count_d = '0;
                  tail_d  = head_q;
                end else if (count_q != '0) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = ptr_dec(tail_q);
                  rd_d        = ptr_dec(tail_q);
                  left_d      = count_q;
                  state_d     = S_QUIT_SCAN;
                end
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_INS_SCAN: begin
        mem_we_o = 1'b1;
        if (later) begin
          // shift this entry one slot toward the tail
          mem_wdata_o = mem_rdata_i;
          wr_d        = rd_q;
          if (left_q == CW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            mem_re_o = 1'b1;
            rd_d     = ptr_dec(rd_q);
            left_d   = left_q - 1'b1;
          end
        end else begin
          // place the new entry behind this one
          tail_d  = ptr_inc(tail_q);
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end
      end

      S_INS_PUT: begin
        mem_we_o = 1'b1;
        tail_d   = ptr_inc(tail_q);
        count_d  = count_q + 1'b1;
        state_d  = S_DONE;
      end

      S_POP: begin
        out_hdl_d = rd_handle;
        head_d    = ptr_inc(head_q);
        count_d   = count_q - 1'b1;
        state_d   = S_DONE;
      end

      S_QUIT_SCAN: begin
        if (later) begin
          // drop the tail entry
          count_d = count_q - 1'b1;
          tail_d  = rd_q;
          if (left_q == CW'(1)) begin
            state_d = S_DONE;
          end else begin
            mem_re_o = 1'b1;
            rd_d     = ptr_dec(rd_q);
            left_d   = left_q - 1'b1;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/timed_message_queue.sv */
// ----------------------------------------------------------------------------
// timed_message_queue
// Queue of message handles kept sorted by due time, held as a circular
// buffer in one slot memory.
//
//   channel  modport  direction  payload
//   in_i     sink     request    mode, msg_handle, due_time, has_target,
//                                already_used, safe_quit, time_now
//   out_o    source   result     status, out_handle
//
// Rejected or immediate operations, front inserts and plain quit finish
// without a memory read; take next makes one memory read. A timed insert
// into a non-empty queue or a safe quit scans the slot memory backward from
// the tail, one entry per cycle through the single read port.
// Reset empties the queue and clears the quit flag; no clearing pass.
// A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module timed_message_queue
  import tmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmq_in_if.sink     in_i,
  tmq_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned DW = TIME_BITS + HANDLE_BITS;

  logic                   res_valid;
  logic                   res_ready;
  status_e                res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [DW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [IW-1:0]          mem_raddr;
  logic [DW-1:0]          mem_rdata;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [HANDLE_BITS-1:0] out_handle_q;

  tmq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_handle_o (res_handle),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tmq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_status_q <= res_status;
      out_handle_q <= res_handle;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_handle = out_handle_q;

endmodule
